@@ rtl/cpu_utilization_delta_meter_assert.svh @@
// cpu_utilization_delta_meter_assert.svh: assertion macros shared by the meter RTL.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef CPU_UTILIZATION_DELTA_METER_ASSERT_SVH
`define CPU_UTILIZATION_DELTA_METER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define CUDM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cudm: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define CUDM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cudm: next-cycle check failed");
`else
`define CUDM_ASSERT_SAME(lbl, ante, cons)
`define CUDM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/cudm_pkg.sv @@
// cudm_pkg.sv: constants and control types of the CPU utilization delta meter.
// No dependencies; imported by every meter module.
`default_nettype none

package cudm_pkg;

    localparam int MAX_ENTRIES  = 64;
    localparam int ENTRY_BITS   = 6;
    localparam int COUNTER_BITS = 48;
    localparam int NUM_COUNTERS = 7;
    localparam int ADDR_BITS    = $clog2(MAX_ENTRIES);

    // Counter order: user, nice, system, idle, iowait, irq, softirq.
    // Busy time is everything except idle and iowait.
    localparam logic [NUM_COUNTERS-1:0] BUSY_MASK = 7'b1100111;

    // Result format: 100 * ratio in unsigned Q7.8.
    localparam int PCT_BITS  = 15;
    localparam int FRAC_BITS = 8;
    localparam int SCALE     = 100;
    localparam int FULL_Q8   = SCALE << FRAC_BITS;
    localparam int PRE_SHIFT = PCT_BITS - FRAC_BITS;

    // Serial datapath geometry.
    localparam int SUM_BITS      = COUNTER_BITS + 3;
    localparam int DIGIT_BITS    = 8;
    localparam int WORD_BITS     =
        ((SUM_BITS + $clog2(SCALE) + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS;
    localparam int NUM_DIGITS    = WORD_BITS / DIGIT_BITS;
    localparam int DIG_CNT_BITS  = $clog2(NUM_DIGITS);
    localparam int STEP_CNT_BITS = $clog2(PCT_BITS);
    localparam int CARRY_BITS    = $clog2(NUM_COUNTERS);
    localparam int MUL_CARRY_BITS = $clog2(SCALE);

    // State store entry: {user seen, busy sum, total sum}.
    localparam int RAM_BITS = 2 * SUM_BITS + 1;

    // Stream widths.
    localparam int IN_FIELD_BITS  = ENTRY_BITS + NUM_COUNTERS * COUNTER_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = PCT_BITS + ENTRY_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_FIELD_BITS;

    typedef struct packed {
        logic capture;    // take the counters of an accepted request
        logic load_prev;  // take the stored sums from the state memory
        logic sum_step;   // one digit of the sum and delta pass
        logic mag_step;   // one digit of the magnitude, scale and compare pass
    } cudm_front_ctrl_t;

    typedef struct packed {
        logic db_zero;
        logic dt_zero;
        logic neg_b;
        logic neg_t;
        logic db_ge_dt;
        logic user_nz;
    } cudm_front_stat_t;

    typedef struct packed {
        logic start;
        logic step;
        logic first;
        logic last;
    } cudm_div_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/cudm_state_ram.sv @@
// cudm_state_ram.sv: per-entry store of previous busy sum, total sum and user flag.
// Depends on cudm_pkg; entries never written since reset read as zero.
`default_nettype none

module cudm_state_ram (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [cudm_pkg::ADDR_BITS-1:0]  rd_addr,
    input  logic                            wr_en,
    input  logic [cudm_pkg::ADDR_BITS-1:0]  wr_addr,
    input  logic [cudm_pkg::RAM_BITS-1:0]   wr_data,
    output logic [cudm_pkg::RAM_BITS-1:0]   rd_data
);
    import cudm_pkg::*;

    logic [RAM_BITS-1:0]    mem [MAX_ENTRIES];
    logic [RAM_BITS-1:0]    rd_data_reg;
    logic                   rd_valid_reg;
    logic [MAX_ENTRIES-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

@@ rtl/cudm_serial_front.sv @@
// cudm_serial_front.sv: digit-serial sums, signed deltas, magnitudes, x100 and compare.
// Depends on cudm_pkg; driven digit by digit by the top-level sequencer.
`default_nettype none

module cudm_serial_front (
    input  logic                               clk,
    input  cudm_pkg::cudm_front_ctrl_t         ctrl,
    input  logic [cudm_pkg::COUNTER_BITS-1:0]  counters [cudm_pkg::NUM_COUNTERS],
    input  logic [cudm_pkg::SUM_BITS-1:0]      prev_busy,
    input  logic [cudm_pkg::SUM_BITS-1:0]      prev_total,
    output logic [cudm_pkg::SUM_BITS-1:0]      busy_sum,
    output logic [cudm_pkg::SUM_BITS-1:0]      total_sum,
    output logic [cudm_pkg::WORD_BITS-1:0]     dt_mag,
    output logic [cudm_pkg::WORD_BITS-1:0]     scaled_db,
    output cudm_pkg::cudm_front_stat_t         stat
);
    import cudm_pkg::*;

    localparam int SUM_DIG_BITS = DIGIT_BITS + CARRY_BITS;
    localparam int PROD_BITS    = DIGIT_BITS + MUL_CARRY_BITS;

    logic [WORD_BITS-1:0]      cnt_sr_reg [NUM_COUNTERS];
    logic [WORD_BITS-1:0]      pbusy_sr_reg;
    logic [WORD_BITS-1:0]      ptotal_sr_reg;
    logic [WORD_BITS-1:0]      busy_sr_reg;
    logic [WORD_BITS-1:0]      total_sr_reg;
    logic [WORD_BITS-1:0]      db_sr_reg;
    logic [WORD_BITS-1:0]      dt_sr_reg;
    logic [WORD_BITS-1:0]      m_sr_reg;
    logic [CARRY_BITS-1:0]     cb_reg;
    logic [CARRY_BITS-1:0]     ct_reg;
    logic                      bb_reg;
    logic                      bt_reg;
    logic                      user_nz_reg;
    logic                      nc_b_reg;
    logic                      nc_t_reg;
    logic [MUL_CARRY_BITS-1:0] mc_reg;
    logic                      cmp_reg;
    logic                      nzb_reg;
    logic                      nzt_reg;

    logic [SUM_DIG_BITS-1:0]   bsum;
    logic [SUM_DIG_BITS-1:0]   tsum;
    logic [DIGIT_BITS:0]       db_dig;
    logic [DIGIT_BITS:0]       dt_dig;
    logic [DIGIT_BITS:0]       neg_b_dig;
    logic [DIGIT_BITS:0]       neg_t_dig;
    logic [DIGIT_BITS-1:0]     mag_b;
    logic [DIGIT_BITS-1:0]     mag_t;
    logic [PROD_BITS-1:0]      prod;
    logic [DIGIT_BITS:0]       cmp_dig;

    // Pass one: column sums of the counter digits, then subtract the stored sums.
    always_comb
    begin
        bsum = SUM_DIG_BITS'(cb_reg);
        tsum = SUM_DIG_BITS'(ct_reg);
        for (int i = 0; i < NUM_COUNTERS; i++)
        begin
            tsum = tsum + SUM_DIG_BITS'(cnt_sr_reg[i][DIGIT_BITS-1:0]);
            if (BUSY_MASK[i])
            begin
                bsum = bsum + SUM_DIG_BITS'(cnt_sr_reg[i][DIGIT_BITS-1:0]);
            end
        end
        db_dig = {1'b0, bsum[DIGIT_BITS-1:0]} - {1'b0, pbusy_sr_reg[DIGIT_BITS-1:0]}
                 - (DIGIT_BITS + 1)'(bb_reg);
        dt_dig = {1'b0, tsum[DIGIT_BITS-1:0]} - {1'b0, ptotal_sr_reg[DIGIT_BITS-1:0]}
                 - (DIGIT_BITS + 1)'(bt_reg);
    end

    // Pass two: two's complement magnitudes, busy delta times 100, and |db| - |dt|.
    always_comb
    begin
        neg_b_dig = {1'b0, ~db_sr_reg[DIGIT_BITS-1:0]} + (DIGIT_BITS + 1)'(nc_b_reg);
        neg_t_dig = {1'b0, ~dt_sr_reg[DIGIT_BITS-1:0]} + (DIGIT_BITS + 1)'(nc_t_reg);
        mag_b     = bb_reg ? neg_b_dig[DIGIT_BITS-1:0] : db_sr_reg[DIGIT_BITS-1:0];
        mag_t     = bt_reg ? neg_t_dig[DIGIT_BITS-1:0] : dt_sr_reg[DIGIT_BITS-1:0];
        prod      = PROD_BITS'(mag_b) * PROD_BITS'(SCALE) + PROD_BITS'(mc_reg);
        cmp_dig   = {1'b0, mag_b} - {1'b0, mag_t} - (DIGIT_BITS + 1)'(cmp_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                cnt_sr_reg[i] <= WORD_BITS'(counters[i]);
            end
        end
        else if (ctrl.sum_step)
        begin
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                cnt_sr_reg[i] <= cnt_sr_reg[i] >> DIGIT_BITS;
            end
        end

        if (ctrl.load_prev)
        begin
            pbusy_sr_reg  <= WORD_BITS'(prev_busy);
            ptotal_sr_reg <= WORD_BITS'(prev_total);
            cb_reg        <= '0;
            ct_reg        <= '0;
            bb_reg        <= 1'b0;
            bt_reg        <= 1'b0;
            user_nz_reg   <= 1'b0;
            nc_b_reg      <= 1'b1;
            nc_t_reg      <= 1'b1;
            mc_reg        <= '0;
            cmp_reg       <= 1'b0;
            nzb_reg       <= 1'b0;
            nzt_reg       <= 1'b0;
        end
        else if (ctrl.sum_step)
        begin
            pbusy_sr_reg  <= pbusy_sr_reg >> DIGIT_BITS;
            ptotal_sr_reg <= ptotal_sr_reg >> DIGIT_BITS;
            busy_sr_reg   <= {bsum[DIGIT_BITS-1:0], busy_sr_reg[WORD_BITS-1:DIGIT_BITS]};
            total_sr_reg  <= {tsum[DIGIT_BITS-1:0], total_sr_reg[WORD_BITS-1:DIGIT_BITS]};
            db_sr_reg     <= {db_dig[DIGIT_BITS-1:0], db_sr_reg[WORD_BITS-1:DIGIT_BITS]};
            dt_sr_reg     <= {dt_dig[DIGIT_BITS-1:0], dt_sr_reg[WORD_BITS-1:DIGIT_BITS]};
            cb_reg        <= bsum[SUM_DIG_BITS-1:DIGIT_BITS];
            ct_reg        <= tsum[SUM_DIG_BITS-1:DIGIT_BITS];
            bb_reg        <= db_dig[DIGIT_BITS];
            bt_reg        <= dt_dig[DIGIT_BITS];
            user_nz_reg   <= user_nz_reg | (|cnt_sr_reg[0][DIGIT_BITS-1:0]);
        end
        else if (ctrl.mag_step)
        begin
            // The delta registers are overwritten in place by their magnitudes.
            db_sr_reg <= {mag_b, db_sr_reg[WORD_BITS-1:DIGIT_BITS]};
            dt_sr_reg <= {mag_t, dt_sr_reg[WORD_BITS-1:DIGIT_BITS]};
            m_sr_reg  <= {prod[DIGIT_BITS-1:0], m_sr_reg[WORD_BITS-1:DIGIT_BITS]};
            nc_b_reg  <= neg_b_dig[DIGIT_BITS];
            nc_t_reg  <= neg_t_dig[DIGIT_BITS];
            mc_reg    <= prod[PROD_BITS-1:DIGIT_BITS];
            cmp_reg   <= cmp_dig[DIGIT_BITS];
            nzb_reg   <= nzb_reg | (|mag_b);
            nzt_reg   <= nzt_reg | (|mag_t);
        end
    end

    assign busy_sum      = busy_sr_reg[SUM_BITS-1:0];
    assign total_sum     = total_sr_reg[SUM_BITS-1:0];
    assign dt_mag        = dt_sr_reg;
    assign scaled_db     = m_sr_reg;
    assign stat.db_zero  = !nzb_reg;
    assign stat.dt_zero  = !nzt_reg;
    assign stat.neg_b    = bb_reg;
    assign stat.neg_t    = bt_reg;
    assign stat.db_ge_dt = !cmp_reg;
    assign stat.user_nz  = user_nz_reg;

endmodule

`default_nettype wire

@@ rtl/cudm_serial_div.sv @@
// cudm_serial_div.sv: restoring divider, one quotient bit per pass of NUM_DIGITS digits.
// Depends on cudm_pkg; yields floor(scaled_db * 256 / dt_mag) as a PCT_BITS quotient.
`default_nettype none

module cudm_serial_div (
    input  logic                            clk,
    input  cudm_pkg::cudm_div_ctrl_t        ctrl,
    input  logic [cudm_pkg::WORD_BITS-1:0]  dvs_word,
    input  logic [cudm_pkg::WORD_BITS-1:0]  num_word,
    output logic [cudm_pkg::PCT_BITS-1:0]   quo
);
    import cudm_pkg::*;

    logic [WORD_BITS-1:0]  dvs_reg;
    logic [WORD_BITS-1:0]  rem_reg;
    logic [WORD_BITS-1:0]  trial_reg;
    logic                  borrow_reg;
    logic                  lsb_reg;
    logic [PCT_BITS-1:0]   num_bits_reg;
    logic [PCT_BITS-1:0]   quo_reg;

    logic [DIGIT_BITS-1:0] rem_dig;
    logic [DIGIT_BITS-1:0] sh_dig;
    logic                  shin;
    logic                  bw_in;
    logic [DIGIT_BITS:0]   diff;

    // The remainder is doubled and the next numerator bit enters at the bottom,
    // while the divisor is subtracted from the doubled value digit by digit.
    always_comb
    begin
        rem_dig = rem_reg[DIGIT_BITS-1:0];
        shin    = ctrl.first ? num_bits_reg[PCT_BITS-1] : lsb_reg;
        sh_dig  = {rem_dig[DIGIT_BITS-2:0], shin};
        bw_in   = ctrl.first ? 1'b0 : borrow_reg;
        diff    = {1'b0, sh_dig} - {1'b0, dvs_reg[DIGIT_BITS-1:0]}
                  - (DIGIT_BITS + 1)'(bw_in);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            dvs_reg      <= dvs_word;
            rem_reg      <= num_word >> PRE_SHIFT;
            num_bits_reg <= {num_word[PRE_SHIFT-1:0], {FRAC_BITS{1'b0}}};
            quo_reg      <= '0;
        end
        else if (ctrl.step)
        begin
            dvs_reg    <= {dvs_reg[DIGIT_BITS-1:0], dvs_reg[WORD_BITS-1:DIGIT_BITS]};
            trial_reg  <= {diff[DIGIT_BITS-1:0], trial_reg[WORD_BITS-1:DIGIT_BITS]};
            borrow_reg <= diff[DIGIT_BITS];
            lsb_reg    <= rem_dig[DIGIT_BITS-1];
            if (ctrl.last && !diff[DIGIT_BITS])
            begin
                rem_reg <= {diff[DIGIT_BITS-1:0], trial_reg[WORD_BITS-1:DIGIT_BITS]};
            end
            else
            begin
                rem_reg <= {sh_dig, rem_reg[WORD_BITS-1:DIGIT_BITS]};
            end
            if (ctrl.last)
            begin
                quo_reg      <= {quo_reg[PCT_BITS-2:0], !diff[DIGIT_BITS]};
                num_bits_reg <= {num_bits_reg[PCT_BITS-2:0], 1'b0};
            end
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

@@ rtl/cpu_utilization_delta_meter.sv @@
// cpu_utilization_delta_meter.sv: top level of the CPU utilization delta meter.
// Depends on cudm_pkg, cudm_state_ram, cudm_serial_front, cudm_serial_div and the
// assertion header cpu_utilization_delta_meter_assert.svh.
//
//  Channel   Direction  Handshake                    Contents
//  s_axis    in         s_axis_tvalid/s_axis_tready  entry and seven time counters
//  m_axis    out        m_axis_tvalid/m_axis_tready  percent, entry echo; tuser = valid
//
// One request is worked on at a time; a new request is accepted only once the last
// result has been handed to the output register. No division is needed for a first
// sample, an out-of-range entry, zero change, busy and total changes of opposite sign
// or a ratio of one or more; otherwise the divider runs, which handles one 8-bit
// digit per cycle and one quotient bit per pass over the word.
// Reset is asynchronous and active low; it clears the sequencer, the output
// register and the valid bits of the state memory, so every entry reads as zero.
// A finished result waits in the output register while the next request is taken;
// the sequencer holds only if a second result is ready before the first is taken.
`default_nettype none
`include "cpu_utilization_delta_meter_assert.svh"

module cpu_utilization_delta_meter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata from bit 0: entry, user_time, nice_time, system_time, idle_time,
    // iowait_time, irq_time, softirq_time, zero padding.
    input  logic [cudm_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata from bit 0: percent_q8, entry_echo, zero padding.
    output logic [cudm_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
    // tuser: percent_valid.
    output logic                                 m_axis_tuser
);
    import cudm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SUM,
        ST_MAG,
        ST_DECIDE,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                   state_reg, state_next;
    logic [DIG_CNT_BITS-1:0]  dig_cnt_reg, dig_cnt_next;
    logic [STEP_CNT_BITS-1:0] step_cnt_reg, step_cnt_next;
    logic [ENTRY_BITS-1:0]    entry_reg, entry_next;
    logic                     in_range_reg, in_range_next;
    logic                     prev_seen_reg, prev_seen_next;
    logic                     res_valid_reg, res_valid_next;
    logic [PCT_BITS-1:0]      res_pct_reg, res_pct_next;
    logic                     use_div_reg, use_div_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_pv_reg, out_pv_next;
    logic [PCT_BITS-1:0]      out_pct_reg, out_pct_next;
    logic [ENTRY_BITS-1:0]    out_entry_reg, out_entry_next;

    logic                     in_fire;
    logic                     dig_last;
    logic                     div_start;
    logic [ENTRY_BITS-1:0]    in_entry;
    logic [COUNTER_BITS-1:0]  in_counters [NUM_COUNTERS];

    cudm_front_ctrl_t         front_ctrl;
    cudm_front_stat_t         front_stat;
    cudm_div_ctrl_t           div_ctrl;

    logic                     ram_wr_en;
    logic [RAM_BITS-1:0]      ram_rd_data;
    logic [SUM_BITS-1:0]      busy_sum;
    logic [SUM_BITS-1:0]      total_sum;
    logic [WORD_BITS-1:0]     dt_mag;
    logic [WORD_BITS-1:0]     scaled_db;
    logic [PCT_BITS-1:0]      div_quo;

    // Request unpacking.
    assign in_entry = s_axis_tdata[ENTRY_BITS-1:0];
    always_comb
    begin
        for (int i = 0; i < NUM_COUNTERS; i++)
        begin
            in_counters[i] = s_axis_tdata[ENTRY_BITS + i * COUNTER_BITS +: COUNTER_BITS];
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign dig_last      = (dig_cnt_reg == DIG_CNT_BITS'(NUM_DIGITS - 1));

    assign front_ctrl.capture   = in_fire;
    assign front_ctrl.load_prev = (state_reg == ST_LOAD);
    assign front_ctrl.sum_step  = (state_reg == ST_SUM);
    assign front_ctrl.mag_step  = (state_reg == ST_MAG);

    assign div_ctrl.start = div_start;
    assign div_ctrl.step  = (state_reg == ST_DIV);
    assign div_ctrl.first = (dig_cnt_reg == '0);
    assign div_ctrl.last  = dig_last;

    // The new sums are complete after the sum pass; they are written back as the
    // magnitude pass begins, at digit zero. Out-of-range entries leave the store alone.
    assign ram_wr_en = (state_reg == ST_MAG) && (dig_cnt_reg == '0) && in_range_reg;

    cudm_state_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (ADDR_BITS'(in_entry)),
        .wr_en   (ram_wr_en),
        .wr_addr (ADDR_BITS'(entry_reg)),
        .wr_data ({front_stat.user_nz, busy_sum, total_sum}),
        .rd_data (ram_rd_data)
    );

    cudm_serial_front u_front (
        .clk        (clk),
        .ctrl       (front_ctrl),
        .counters   (in_counters),
        .prev_busy  (ram_rd_data[2*SUM_BITS-1:SUM_BITS]),
        .prev_total (ram_rd_data[SUM_BITS-1:0]),
        .busy_sum   (busy_sum),
        .total_sum  (total_sum),
        .dt_mag     (dt_mag),
        .scaled_db  (scaled_db),
        .stat       (front_stat)
    );

    cudm_serial_div u_div (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .dvs_word (dt_mag),
        .num_word (scaled_db),
        .quo      (div_quo)
    );

    // Sequencer: load the stored sums, run the two digit passes, classify the
    // request, divide if the ratio is strictly between zero and one, post the result.
    always_comb
    begin
        state_next     = state_reg;
        dig_cnt_next   = dig_cnt_reg;
        step_cnt_next  = step_cnt_reg;
        entry_next     = entry_reg;
        in_range_next  = in_range_reg;
        prev_seen_next = prev_seen_reg;
        res_valid_next = res_valid_reg;
        res_pct_next   = res_pct_reg;
        use_div_next   = use_div_reg;
        out_valid_next = out_valid_reg;
        out_pv_next    = out_pv_reg;
        out_pct_next   = out_pct_reg;
        out_entry_next = out_entry_reg;
        div_start      = 1'b0;

        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    entry_next    = in_entry;
                    in_range_next = (int'(in_entry) < MAX_ENTRIES);
                    state_next    = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                prev_seen_next = ram_rd_data[RAM_BITS-1];
                dig_cnt_next   = '0;
                state_next     = ST_SUM;
            end
            ST_SUM:
            begin
                dig_cnt_next = dig_cnt_reg + 1'b1;
                if (dig_last)
                begin
                    dig_cnt_next = '0;
                    state_next   = ST_MAG;
                end
            end
            ST_MAG:
            begin
                dig_cnt_next = dig_cnt_reg + 1'b1;
                if (dig_last)
                begin
                    dig_cnt_next = '0;
                    state_next   = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                res_valid_next = in_range_reg && prev_seen_reg && !front_stat.dt_zero;
                res_pct_next   = '0;
                use_div_next   = 1'b0;
                state_next     = ST_FINISH;
                priority if (!res_valid_next)
                begin
                    res_pct_next = '0;
                end
                else if (front_stat.db_zero || (front_stat.neg_b != front_stat.neg_t))
                begin
                    res_pct_next = '0;
                end
                else if (front_stat.db_ge_dt)
                begin
                    res_pct_next = PCT_BITS'(FULL_Q8);
                end
                else
                begin
                    use_div_next  = 1'b1;
                    div_start     = 1'b1;
                    dig_cnt_next  = '0;
                    step_cnt_next = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                dig_cnt_next = dig_cnt_reg + 1'b1;
                if (dig_last)
                begin
                    dig_cnt_next  = '0;
                    step_cnt_next = step_cnt_reg + 1'b1;
                    if (step_cnt_reg == STEP_CNT_BITS'(PCT_BITS - 1))
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_pv_next    = res_valid_reg;
                    out_pct_next   = use_div_reg ? div_quo : res_pct_reg;
                    out_entry_next = entry_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dig_cnt_reg   <= '0;
            step_cnt_reg  <= '0;
            entry_reg     <= '0;
            in_range_reg  <= 1'b0;
            prev_seen_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            res_pct_reg   <= '0;
            use_div_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_pv_reg    <= 1'b0;
            out_pct_reg   <= '0;
            out_entry_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            dig_cnt_reg   <= dig_cnt_next;
            step_cnt_reg  <= step_cnt_next;
            entry_reg     <= entry_next;
            in_range_reg  <= in_range_next;
            prev_seen_reg <= prev_seen_next;
            res_valid_reg <= res_valid_next;
            res_pct_reg   <= res_pct_next;
            use_div_reg   <= use_div_next;
            out_valid_reg <= out_valid_next;
            out_pv_reg    <= out_pv_next;
            out_pct_reg   <= out_pct_next;
            out_entry_reg <= out_entry_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_BITS{1'b0}}, out_entry_reg, out_pct_reg};
    assign m_axis_tuser  = out_pv_reg;

    // A posted percentage never exceeds 100, and an invalid result carries zero.
    `CUDM_ASSERT_SAME(a_pct_range, m_axis_tvalid, out_pct_reg <= PCT_BITS'(FULL_Q8))
    `CUDM_ASSERT_SAME(a_invalid_zero, m_axis_tvalid && !out_pv_reg, out_pct_reg == '0)
    // Only one request is in the datapath at a time.
    `CUDM_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A finished result that finds room in the output register is posted.
    `CUDM_ASSERT_NEXT(a_result_posted,
        state_reg == ST_FINISH && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid)

endmodule

`default_nettype wire
